### hdl/fair_value_gap_tracker_top_defines.svh
// Assertion macros for the fair value gap tracker.
// Included by the top level; uses the clk and rst_n names of the including module.
`ifndef FAIR_VALUE_GAP_TRACKER_TOP_DEFINES_SVH
`define FAIR_VALUE_GAP_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FVG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FVG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/fvg_pkg.sv
// Shared types and constants of the fair value gap tracker.
// No dependencies; imported by every module and interface of the block.
package fvg_pkg;

  localparam int WINDOW     = 32;
  localparam int PRICE_BITS = 32;
  localparam int IDX_W      = $clog2(WINDOW);
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int LB_W       = 6;
  localparam int MIN_W      = 32;
  localparam int PCT_W      = 7;
  localparam int NUM_W      = PRICE_BITS + PCT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  localparam logic [CFG_IDX_W-1:0] REG_LOOKBACK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP  = 2'd1;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_BULL = 2'd1,
    KIND_BEAR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [PRICE_BITS-1:0] top;
    logic [PRICE_BITS-1:0] bottom;
    logic [PRICE_BITS-1:0] pen;
  } slot_t;

  typedef struct packed {
    logic bull;
    logic bear;
    logic unf;
  } cell_flags_t;

  typedef struct packed {
    logic [CNT_W-1:0] bull_cnt;
    logic [CNT_W-1:0] bear_cnt;
    logic [CNT_W-1:0] unf_cnt;
    logic             found;
    logic [IDX_W-1:0] idx;
  } summary_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLAGS,
    S_SCAN,
    S_PICK,
    S_MULT,
    S_DIV,
    S_DONE
  } state_t;

endpackage

### hdl/fvg_in_if.sv
// Candle input channel: valid/ready handshake with high and low prices.
// Depends on fvg_pkg.
interface fvg_in_if import fvg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] candle_high;
  logic [PRICE_BITS-1:0] candle_low;

  modport source (output valid, candle_high, candle_low, input ready);
  modport sink   (input valid, candle_high, candle_low, output ready);
endinterface

### hdl/fvg_out_if.sv
// Result channel: valid/ready handshake carrying one summary word per candle.
// Depends on fvg_pkg.
interface fvg_out_if import fvg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            new_gap_kind;
  logic [CNT_W-1:0]      bullish_count;
  logic [CNT_W-1:0]      bearish_count;
  logic [CNT_W-1:0]      unfilled_count;
  logic                  newest_valid;
  logic                  newest_direction;
  logic [PRICE_BITS-1:0] newest_remaining_top;
  logic [PRICE_BITS-1:0] newest_remaining_bottom;
  logic [PCT_W-1:0]      newest_fill_percent;

  modport source (output valid, new_gap_kind, bullish_count, bearish_count, unfilled_count,
                  newest_valid, newest_direction, newest_remaining_top,
                  newest_remaining_bottom, newest_fill_percent, input ready);
  modport sink   (input valid, new_gap_kind, bullish_count, bearish_count, unfilled_count,
                  newest_valid, newest_direction, newest_remaining_top,
                  newest_remaining_bottom, newest_fill_percent, output ready);
endinterface

### hdl/fvg_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on fvg_pkg.
interface fvg_cfg_if import fvg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/fair_value_gap_tracker_top.sv
// Fair value gap tracker: one candle word in, one summary word out.
// Input channel in_ch carries candle_high and candle_low; a word is taken when
// valid and ready are both high, and ready is high only while no candle is in
// work. Each candle produces exactly one word on out_ch: the gap kind formed at
// this candle, bullish, bearish and unfilled counts over the lookback window,
// and the newest unfilled gap's remaining bounds and floor fill percent.
// From acceptance to out_ch.valid the candle passes flag capture, window
// summary, the pick of the newest slot, the multiply, the divider load, the
// steps of the restoring divider, a state in which the sequencer sees the
// divider finish, and the load of the output register.
// Ready returns the cycle after that load, so no new candle is taken until
// the previous one has been loaded into the output register.
// The window is a chain of 32 cells that all update penetration and shift by
// one place at the acceptance edge.
// The output register holds a word until out_ch.ready; while it is held the
// next candle is accepted and worked up to the final load, which waits.
// cfg_ch (always ready) writes lookback at index 0 and min_gap_size at index 1;
// write only while idle. Synchronous active-low reset clears all gaps, the
// candle history, and restores lookback 32 and min_gap_size 0.
// Depends on fvg_pkg, the channel interfaces, fvg_cell, fvg_summary and fvg_div.
`include "fair_value_gap_tracker_top_defines.svh"

module fair_value_gap_tracker_top import fvg_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  fvg_in_if.sink   in_ch,
  fvg_out_if.source out_ch,
  fvg_cfg_if.sink  cfg_ch
);

  state_t state_r, state_nxt;

  logic                  in_acc;
  logic                  flag_load, scan_load, pick_load, mult_load, div_start, out_load;

  // Configuration registers.
  logic [LB_W-1:0]       lookback_r;
  logic [MIN_W-1:0]      min_gap_r;
  logic [LB_W-1:0]       win;

  // Candle history.
  logic [PRICE_BITS-1:0] ph0_r, ph1_r, pl0_r, pl1_r;
  logic [1:0]            seen_r;
  kind_t                 kind_r;
  slot_t                 new_rec;

  // Cell chain.
  slot_t                 slot_upd [WINDOW];
  slot_t                 slot_q   [WINDOW];
  cell_flags_t           flags    [WINDOW];
  logic [WINDOW-1:0]     bull_v_r, bear_v_r, unf_v_r;
  summary_t              summ;

  // Newest gap path.
  slot_t                 pick_r;
  logic [PRICE_BITS-1:0] size_r;
  logic [NUM_W-1:0]      num_r;
  logic [PRICE_BITS-1:0] rtop_r, rbot_r;
  logic [PCT_W-1:0]      quot;
  div_stat_t             dstat;

  // Output register.
  logic                  out_valid_r;
  logic [1:0]            o_kind_r;
  logic [CNT_W-1:0]      o_bull_r, o_bear_r, o_unf_r;
  logic                  o_nv_r, o_dir_r;
  logic [PRICE_BITS-1:0] o_top_r, o_bot_r;
  logic [PCT_W-1:0]      o_pct_r;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookback_r <= LB_W'(WINDOW);
      min_gap_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_LOOKBACK: lookback_r <= cfg_ch.data[LB_W-1:0];
        REG_MIN_GAP:  min_gap_r  <= cfg_ch.data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign win = (lookback_r > LB_W'(WINDOW)) ? LB_W'(WINDOW) : lookback_r;

  // Gap formed by this candle against the candle two back; bullish test first.
  always_comb begin
    new_rec = '0;
    if (seen_r == 2'd2) begin
      if (ph1_r < in_ch.candle_low) begin
        new_rec.kind   = KIND_BULL;
        new_rec.bottom = ph1_r;
        new_rec.top    = in_ch.candle_low;
      end else if (pl1_r > in_ch.candle_high) begin
        new_rec.kind   = KIND_BEAR;
        new_rec.bottom = in_ch.candle_high;
        new_rec.top    = pl1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph0_r  <= '0;
      ph1_r  <= '0;
      pl0_r  <= '0;
      pl1_r  <= '0;
      seen_r <= '0;
      kind_r <= KIND_NONE;
    end else if (in_acc) begin
      ph1_r  <= ph0_r;
      pl1_r  <= pl0_r;
      ph0_r  <= in_ch.candle_high;
      pl0_r  <= in_ch.candle_low;
      kind_r <= new_rec.kind;
      if (seen_r != 2'd2) begin
        seen_r <= seen_r + 2'd1;
      end
    end
  end

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    fvg_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .shift_en    (in_acc),
      .candle_high (in_ch.candle_high),
      .candle_low  (in_ch.candle_low),
      .slot_in     ((i == 0) ? new_rec : slot_upd[(i == 0) ? 0 : i - 1]),
      .in_win      (win > LB_W'(i)),
      .min_gap     (min_gap_r),
      .slot_upd    (slot_upd[i]),
      .slot_q      (slot_q[i]),
      .flags       (flags[i])
    );
  end

  // Window flags of all cells, captured together once the shift has settled.
  always_ff @(posedge clk) begin
    if (flag_load) begin
      for (int i = 0; i < WINDOW; i++) begin
        bull_v_r[i] <= flags[i].bull;
        bear_v_r[i] <= flags[i].bear;
        unf_v_r[i]  <= flags[i].unf;
      end
    end
  end

  fvg_summary u_summary (
    .clk    (clk),
    .load   (scan_load),
    .bull_v (bull_v_r),
    .bear_v (bear_v_r),
    .unf_v  (unf_v_r),
    .summ   (summ)
  );

  always_ff @(posedge clk) begin
    if (pick_load) begin
      pick_r <= slot_q[summ.idx];
    end
    if (mult_load) begin
      size_r <= pick_r.top - pick_r.bottom;
      num_r  <= NUM_W'(pick_r.pen) * NUM_W'(PCT_SCALE);
      if (pick_r.kind == KIND_BULL) begin
        rtop_r <= pick_r.top;
        rbot_r <= pick_r.top - pick_r.pen;
      end else begin
        rtop_r <= pick_r.bottom + pick_r.pen;
        rbot_r <= pick_r.bottom;
      end
    end
  end

  fvg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (size_r),
    .quot  (quot),
    .stat  (dstat)
  );

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_FLAGS;
      S_FLAGS: state_nxt = S_SCAN;
      S_SCAN:  state_nxt = S_PICK;
      S_PICK:  state_nxt = S_MULT;
      S_MULT:  state_nxt = S_DIV;
      S_DIV:   if (dstat.done) state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    flag_load   = 1'b0;
    scan_load   = 1'b0;
    pick_load   = 1'b0;
    mult_load   = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ch.ready = 1'b1;
      S_FLAGS: flag_load   = 1'b1;
      S_SCAN:  scan_load   = 1'b1;
      S_PICK:  pick_load   = 1'b1;
      S_MULT:  mult_load   = 1'b1;
      S_DIV:   div_start   = !dstat.busy && !dstat.done && state_r != state_nxt ? 1'b0
                             : !dstat.busy && !dstat.done;
      S_DONE:  out_load    = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register; a held word is dropped once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_kind_r <= kind_r;
      o_bull_r <= summ.bull_cnt;
      o_bear_r <= summ.bear_cnt;
      o_unf_r  <= summ.unf_cnt;
      o_nv_r   <= summ.found;
      o_dir_r  <= summ.found && pick_r.kind == KIND_BEAR;
      o_top_r  <= summ.found ? rtop_r : '0;
      o_bot_r  <= summ.found ? rbot_r : '0;
      o_pct_r  <= summ.found ? quot : '0;
    end
  end

  assign out_ch.valid                   = out_valid_r;
  assign out_ch.new_gap_kind            = o_kind_r;
  assign out_ch.bullish_count           = o_bull_r;
  assign out_ch.bearish_count           = o_bear_r;
  assign out_ch.unfilled_count          = o_unf_r;
  assign out_ch.newest_valid            = o_nv_r;
  assign out_ch.newest_direction        = o_dir_r;
  assign out_ch.newest_remaining_top    = o_top_r;
  assign out_ch.newest_remaining_bottom = o_bot_r;
  assign out_ch.newest_fill_percent     = o_pct_r;

  `FVG_ASSERT_NXT(a_acc_starts, in_acc, state_r == S_FLAGS, "accepted candle did not start work")
  `FVG_ASSERT_IMP(a_pct_range, out_valid_r, o_pct_r <= PCT_W'(99), "fill percent above 99")
  `FVG_ASSERT_IMP(a_empty_zero, out_valid_r && !o_nv_r,
                  o_top_r == '0 && o_bot_r == '0 && o_pct_r == '0 && !o_dir_r,
                  "newest fields nonzero without a newest gap")
  `FVG_ASSERT_IMP(a_unf_bound, out_valid_r,
                  {1'b0, o_unf_r} <= {1'b0, o_bull_r} + {1'b0, o_bear_r},
                  "unfilled count exceeds gap count")

endmodule

### hdl/fvg_cell.sv
// One gap slot of the window chain: penetration update and shift to the next slot.
// Depends on fvg_pkg.
module fvg_cell import fvg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  logic [PRICE_BITS-1:0] candle_high,
  input  logic [PRICE_BITS-1:0] candle_low,
  input  slot_t                 slot_in,
  input  logic                  in_win,
  input  logic [MIN_W-1:0]      min_gap,
  output slot_t                 slot_upd,
  output slot_t                 slot_q,
  output cell_flags_t           flags
);

  slot_t                 slot_r;
  logic [PRICE_BITS-1:0] size;
  logic [PRICE_BITS-1:0] p;
  logic                  hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.kind <= KIND_NONE;
    end else if (shift_en) begin
      slot_r <= slot_in;
    end
  end

  // Deepest penetration by the incoming candle, capped at the gap size.
  always_comb begin
    size = slot_r.top - slot_r.bottom;
    p    = '0;
    hit  = 1'b0;
    if (slot_r.kind == KIND_BULL && candle_low < slot_r.top) begin
      p   = slot_r.top - candle_low;
      hit = 1'b1;
    end else if (slot_r.kind == KIND_BEAR && candle_high > slot_r.bottom) begin
      p   = candle_high - slot_r.bottom;
      hit = 1'b1;
    end
    if (p > size) begin
      p = size;
    end
    slot_upd = slot_r;
    if (hit && p > slot_r.pen) begin
      slot_upd.pen = p;
    end
  end

  assign slot_q     = slot_r;
  assign flags.bull = in_win && slot_r.kind == KIND_BULL;
  assign flags.bear = in_win && slot_r.kind == KIND_BEAR;
  assign flags.unf  = in_win && slot_r.kind != KIND_NONE && size >= min_gap
                      && slot_r.pen < size;

endmodule

### hdl/fvg_summary.sv
// Window summary: registered counts and newest unfilled slot index from cell flags.
// Depends on fvg_pkg.
module fvg_summary import fvg_pkg::*; (
  input  logic              clk,
  input  logic              load,
  input  logic [WINDOW-1:0] bull_v,
  input  logic [WINDOW-1:0] bear_v,
  input  logic [WINDOW-1:0] unf_v,
  output summary_t          summ
);

  summary_t summ_r;
  summary_t summ_nxt;

  always_comb begin
    summ_nxt = '0;
    for (int i = 0; i < WINDOW; i++) begin
      summ_nxt.bull_cnt = summ_nxt.bull_cnt + CNT_W'(bull_v[i]);
      summ_nxt.bear_cnt = summ_nxt.bear_cnt + CNT_W'(bear_v[i]);
      summ_nxt.unf_cnt  = summ_nxt.unf_cnt + CNT_W'(unf_v[i]);
    end
    // Lowest index is the newest position.
    for (int i = WINDOW - 1; i >= 0; i--) begin
      if (unf_v[i]) begin
        summ_nxt.found = 1'b1;
        summ_nxt.idx   = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      summ_r <= summ_nxt;
    end
  end

  assign summ = summ_r;

endmodule

### hdl/fvg_div.sv
// Restoring divider for the fill percent, one quotient bit per cycle.
// Depends on fvg_pkg.
module fvg_div import fvg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [NUM_W-1:0]      num,
  input  logic [PRICE_BITS-1:0] den,
  output logic [PCT_W-1:0]      quot,
  output div_stat_t             stat
);

  localparam int STEP_W = $clog2(PCT_W);

  logic [NUM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  den_r;
  logic [PCT_W-1:0]  q_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic              ge;

  assign ge = rem_r >= den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(PCT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The quotient is below 128, so the divisor starts shifted up by six places.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= {1'b0, den, {(PCT_W - 1){1'b0}}};
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - den_r;
      end
      q_r   <= {q_r[PCT_W-2:0], ge};
      den_r <= den_r >> 1;
    end
  end

  assign quot      = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
